### rtl/mle_pkg.sv
// ----------------------------------------------------------------------------
// Majority leader election package
// Shared codes and types for the leader election block and its channels.
// ----------------------------------------------------------------------------
package mle_pkg;

	localparam logic [2:0] KIND_LINK_UP   = 3'd0;
	localparam logic [2:0] KIND_LINK_DOWN = 3'd1;
	localparam logic [2:0] KIND_PROMISE   = 3'd2;
	localparam logic [2:0] KIND_ACCEPT    = 3'd3;
	localparam logic [2:0] KIND_SUBMIT    = 3'd4;
	localparam logic [2:0] KIND_REJECT    = 3'd5;

	localparam logic [1:0] MSG_PROMISE = 2'd0;
	localparam logic [1:0] MSG_ACCEPT  = 2'd1;
	localparam logic [1:0] MSG_REJECT  = 2'd2;
	localparam logic [1:0] MSG_SUBMIT  = 2'd3;

	localparam logic [2:0] PH_STARTED  = 3'd0;
	localparam logic [2:0] PH_INITIAL  = 3'd1;
	localparam logic [2:0] PH_ACCEPT   = 3'd2;
	localparam logic [2:0] PH_RECOVERY = 3'd3;
	localparam logic [2:0] PH_READY    = 3'd5;

	localparam logic [1:0] REG_HOST_COUNT  = 2'd0;
	localparam logic [1:0] REG_OWN_INDEX   = 2'd1;
	localparam logic [1:0] REG_OWN_SEQUENCE = 2'd2;

	localparam logic [1:0] LEVEL_DOWN = 2'd0;
	localparam logic [1:0] LEVEL_HALF = 2'd1;
	localparam logic [1:0] LEVEL_FULL = 2'd2;

	localparam logic [4:0] NO_LEADER = 5'd16;
	localparam logic [4:0] CNT_MAX   = 5'd31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LINKED,
		ST_SCAN,
		ST_RESPOND,
		ST_EMIT
	} mle_state_t;

endpackage

### rtl/mle_channels.sv
// ----------------------------------------------------------------------------
// Majority leader election channels
// Valid/ready channels for election events and outgoing messages.
// ----------------------------------------------------------------------------
interface mle_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [3:0]  peer;
	logic [63:0] peer_sequence;
	logic        take_sequence;
	logic [3:0]  named_host;

	modport source (output valid, kind, peer, peer_sequence, take_sequence, named_host,
		input ready);
	modport sink (input valid, kind, peer, peer_sequence, take_sequence, named_host,
		output ready);
endinterface

interface mle_msg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  destination;
	logic [1:0]  message;
	logic [63:0] carried_sequence;
	logic [3:0]  carried_host;
	logic        last;

	modport source (output valid, destination, message, carried_sequence, carried_host, last,
		input ready);
	modport sink (input valid, destination, message, carried_sequence, carried_host, last,
		output ready);
endinterface

### rtl/majority_leader_election_unit.sv
// ----------------------------------------------------------------------------
// Majority leader election unit
// Tracks replica links and sequences and sends election messages.
// ----------------------------------------------------------------------------
// One event beat is taken at a time. An event passes through decode, then
// through the linked check when it runs one, and, when it needs the best
// host or the lagging hosts, through a scan of n reads of the sequence
// memory, where n is the effective host count; message beats are then
// loaded into the output register while it is empty or the output side is
// ready. The single 64-bit magnitude comparator, fed one memory read per
// cycle, sets the scan length. The output register holds a finished beat
// while the next event is taken.
module majority_leader_election_unit
	import mle_pkg::*;
#(
	parameter int MAX_HOSTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	mle_event_if.sink           events,
	mle_msg_if.source           messages,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	localparam int IW = $clog2(MAX_HOSTS);
	localparam int CW = $clog2(MAX_HOSTS + 1);

	// Configuration registers.
	logic [4:0]  hc_q;
	logic [3:0]  own_q;
	logic [63:0] own_seq_q;

	// Latched event.
	logic [2:0]  kind_q;
	logic [3:0]  peer_q;
	logic [63:0] pseq_q;
	logic        take_q;
	logic [3:0]  named_q;

	// Election state.
	logic [63:0]          seq_mem [MAX_HOSTS];
	logic [MAX_HOSTS-1:0] seq_vld_q;
	logic [1:0]           lvl_q [MAX_HOSTS];
	logic [4:0]           lc_q;
	logic [2:0]           phase_q;
	logic [4:0]           leader_q;
	logic [4:0]           acc_q;
	logic [MAX_HOSTS-1:0] lagging_q;

	// Scan unit.
	logic [CW-1:0]        issue_q;
	logic                 scan_vld_s1;
	logic [IW-1:0]        scan_idx_s1;
	logic [63:0]          seq_rd_s1;
	logic [IW-1:0]        best_q;
	logic [63:0]          best_seq_q;
	logic [MAX_HOSTS-1:0] lag_q;

	// Message emission.
	logic [MAX_HOSTS-1:0] emit_mask_q;
	logic [1:0]           emit_msg_q;
	logic [63:0]          emit_seq_q;
	logic [3:0]           emit_host_q;

	logic        out_vld_q;
	logic [3:0]  out_dest_q;
	logic [1:0]  out_msg_q;
	logic [63:0] out_seq_q;
	logic [3:0]  out_host_q;
	logic        out_last_q;

	mle_state_t state_q, state_d;

	// Derived values.
	logic [CW-1:0]        n_w;
	logic [MAX_HOSTS-1:0] n_mask, own_mask, full_mask;
	logic [IW-1:0]        peer_idx;
	logic [1:0]           lvl_peer;
	logic                 peer_bad;
	logic [4:0]           lc_inc, lc_dec, acc_inc;
	logic                 leader_is_own;
	logic [63:0]          seq_eff;
	logic                 full_s1, own_s1, seq_ge;
	logic [63:0]          cmp_b;
	logic [IW-1:0]        pick_idx;
	logic [MAX_HOSTS-1:0] pick_oh, remain;

	// Control strobes.
	logic                 accept_in;
	logic                 mem_we;
	logic [IW-1:0]        mem_wa;
	logic                 lvl_we;
	logic [1:0]           lvl_wd;
	logic                 lc_we;
	logic [4:0]           lc_wd;
	logic                 phase_we;
	logic [2:0]           phase_wd;
	logic                 leader_we;
	logic [4:0]           leader_wd;
	logic                 acc_we;
	logic [4:0]           acc_wd;
	logic                 lag_we;
	logic                 scan_start;
	logic                 emit_load;
	logic [MAX_HOSTS-1:0] emit_mask_d;
	logic [1:0]           emit_msg_d;
	logic [63:0]          emit_seq_d;
	logic [3:0]           emit_host_d;
	logic                 out_load;

	// Configuration port.
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q      <= 5'd1;
			own_q     <= 4'd0;
			own_seq_q <= 64'd0;
		end else if (cfg_we) begin
			case (paddr[4:3])
				REG_HOST_COUNT:   hc_q      <= pwdata[4:0];
				REG_OWN_INDEX:    own_q     <= pwdata[3:0];
				REG_OWN_SEQUENCE: own_seq_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_HOST_COUNT:   prdata = 64'(hc_q);
			REG_OWN_INDEX:    prdata = 64'(own_q);
			REG_OWN_SEQUENCE: prdata = own_seq_q;
			default:          prdata = 64'd0;
		endcase
	end

	// Effective host count and per-host masks.
	always_comb begin
		if (hc_q == 5'd0) begin
			n_w = CW'(1);
		end else if (hc_q > 5'(MAX_HOSTS)) begin
			n_w = CW'(MAX_HOSTS);
		end else begin
			n_w = CW'(hc_q);
		end
		for (int i = 0; i < MAX_HOSTS; i++) begin
			n_mask[i]    = CW'(i) < n_w;
			own_mask[i]  = 4'(i) == own_q;
			full_mask[i] = lvl_q[i] == LEVEL_FULL;
		end
	end

	assign peer_idx      = peer_q[IW-1:0];
	assign lvl_peer      = lvl_q[peer_idx];
	assign peer_bad      = (5'(peer_q) >= 5'(n_w)) || (5'(peer_q) >= 5'(MAX_HOSTS)) ||
		(peer_q == own_q);
	assign lc_inc        = (lc_q == CNT_MAX) ? CNT_MAX : lc_q + 5'd1;
	assign lc_dec        = (lc_q == 5'd0) ? 5'd0 : lc_q - 5'd1;
	assign acc_inc       = (acc_q == CNT_MAX) ? CNT_MAX : acc_q + 5'd1;
	assign leader_is_own = leader_q == {1'b0, own_q};

	// Shared comparator on the scan read stage.
	assign own_s1  = 4'(scan_idx_s1) == own_q;
	assign seq_eff = own_s1 ? own_seq_q : (seq_vld_q[scan_idx_s1] ? seq_rd_s1 : 64'd0);
	assign full_s1 = own_s1 || (lvl_q[scan_idx_s1] == LEVEL_FULL);
	assign cmp_b   = (kind_q == KIND_ACCEPT) ? own_seq_q : best_seq_q;
	assign seq_ge  = seq_eff >= cmp_b;

	// Lowest pending destination.
	always_comb begin
		pick_idx = '0;
		for (int i = MAX_HOSTS - 1; i >= 0; i--) begin
			if (emit_mask_q[i]) begin
				pick_idx = IW'(i);
			end
		end
		pick_oh = MAX_HOSTS'(1) << pick_idx;
		remain  = emit_mask_q & ~pick_oh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		accept_in   = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = peer_idx;
		lvl_we      = 1'b0;
		lvl_wd      = lvl_peer;
		lc_we       = 1'b0;
		lc_wd       = lc_q;
		phase_we    = 1'b0;
		phase_wd    = phase_q;
		leader_we   = 1'b0;
		leader_wd   = leader_q;
		acc_we      = 1'b0;
		acc_wd      = acc_q;
		lag_we      = 1'b0;
		scan_start  = 1'b0;
		emit_load   = 1'b0;
		emit_mask_d = '0;
		emit_msg_d  = MSG_SUBMIT;
		emit_seq_d  = 64'd0;
		emit_host_d = 4'd0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (events.valid) begin
					accept_in = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (!peer_bad) begin
					case (kind_q)
						KIND_LINK_UP: begin
							mem_we = take_q;
							if (lvl_peer != LEVEL_FULL) begin
								lvl_we = 1'b1;
								lvl_wd = lvl_peer + 2'd1;
								if (lvl_peer == LEVEL_HALF) begin
									lc_we   = 1'b1;
									lc_wd   = lc_inc;
									state_d = ST_LINKED;
								end
							end
						end
						KIND_LINK_DOWN: begin
							if (lvl_peer != LEVEL_DOWN) begin
								lvl_we = 1'b1;
								lvl_wd = lvl_peer - 2'd1;
								if (lvl_peer == LEVEL_FULL) begin
									lc_we = 1'b1;
									lc_wd = lc_dec;
									if (({lc_dec, 1'b0} <= 6'(n_w)) ||
										({1'b0, peer_q} == leader_q)) begin
										leader_we = 1'b1;
										leader_wd = NO_LEADER;
										phase_we  = 1'b1;
										phase_wd  = PH_INITIAL;
										state_d   = ST_LINKED;
									end
								end
							end
						end
						KIND_PROMISE: begin
							mem_we     = 1'b1;
							scan_start = 1'b1;
							state_d    = ST_SCAN;
						end
						KIND_ACCEPT: begin
							if (phase_q == PH_ACCEPT) begin
								acc_we = 1'b1;
								acc_wd = acc_inc;
								if ({acc_inc, 1'b0} > 6'(n_w)) begin
									leader_we  = 1'b1;
									leader_wd  = {1'b0, own_q};
									scan_start = 1'b1;
									state_d    = ST_SCAN;
								end
							end
						end
						KIND_SUBMIT: begin
							leader_we = 1'b1;
							leader_wd = {1'b0, peer_q};
							phase_we  = 1'b1;
							phase_wd  = PH_READY;
						end
						KIND_REJECT: begin
							mem_we  = 5'(named_q) < 5'(MAX_HOSTS);
							mem_wa  = named_q[IW-1:0];
							state_d = ST_LINKED;
						end
						default: ;
					endcase
				end
			end
			ST_LINKED: begin
				if (leader_is_own) begin
					emit_load   = 1'b1;
					emit_mask_d = MAX_HOSTS'(1) << peer_idx;
					emit_msg_d  = MSG_SUBMIT;
					state_d     = ST_EMIT;
				end else if (({lc_q, 1'b0} <= 6'(n_w)) || (phase_q > PH_INITIAL)) begin
					state_d = ST_IDLE;
				end else begin
					scan_start = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((issue_q == n_w) && !scan_vld_s1) begin
					state_d = ST_RESPOND;
				end
			end
			ST_RESPOND: begin
				state_d = ST_IDLE;
				case (kind_q)
					KIND_PROMISE: begin
						emit_load   = 1'b1;
						emit_mask_d = MAX_HOSTS'(1) << peer_idx;
						state_d     = ST_EMIT;
						if ((4'(best_q) != peer_q) || (phase_q > PH_INITIAL)) begin
							emit_msg_d  = MSG_REJECT;
							emit_seq_d  = best_seq_q;
							emit_host_d = 4'(best_q);
						end else begin
							emit_msg_d = MSG_ACCEPT;
							phase_we   = 1'b1;
							phase_wd   = PH_ACCEPT;
						end
					end
					KIND_ACCEPT: begin
						lag_we      = 1'b1;
						phase_we    = 1'b1;
						phase_wd    = (lag_q != '0) ? PH_RECOVERY : PH_READY;
						emit_mask_d = full_mask & n_mask & ~own_mask;
						emit_msg_d  = MSG_SUBMIT;
						if (emit_mask_d != '0) begin
							emit_load = 1'b1;
							state_d   = ST_EMIT;
						end
					end
					default: begin
						if (4'(best_q) == own_q) begin
							acc_we      = 1'b1;
							acc_wd      = 5'd1;
							phase_we    = 1'b1;
							phase_wd    = PH_ACCEPT;
							emit_mask_d = n_mask & ~own_mask;
							emit_msg_d  = MSG_PROMISE;
							emit_seq_d  = own_seq_q;
							if (emit_mask_d != '0) begin
								emit_load = 1'b1;
								state_d   = ST_EMIT;
							end
						end
					end
				endcase
			end
			ST_EMIT: begin
				if (!out_vld_q || messages.ready) begin
					out_load = 1'b1;
					if (remain == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Event latch.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			kind_q  <= events.kind;
			peer_q  <= events.peer;
			pseq_q  <= events.peer_sequence;
			take_q  <= events.take_sequence;
			named_q <= events.named_host;
		end
	end

	// Sequence memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			seq_mem[mem_wa] <= pseq_q;
		end
		seq_rd_s1 <= seq_mem[issue_q[IW-1:0]];
	end

	// Election state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_vld_q <= '0;
			for (int i = 0; i < MAX_HOSTS; i++) begin
				lvl_q[i] <= LEVEL_DOWN;
			end
			lc_q      <= 5'd1;
			phase_q   <= PH_STARTED;
			leader_q  <= NO_LEADER;
			acc_q     <= 5'd0;
			lagging_q <= '0;
		end else begin
			if (mem_we) begin
				seq_vld_q[mem_wa] <= 1'b1;
			end
			if (lvl_we) begin
				lvl_q[peer_idx] <= lvl_wd;
			end
			if (lc_we) begin
				lc_q <= lc_wd;
			end
			if (phase_we) begin
				phase_q <= phase_wd;
			end
			if (leader_we) begin
				leader_q <= leader_wd;
			end
			if (acc_we) begin
				acc_q <= acc_wd;
			end
			if (lag_we) begin
				lagging_q <= lag_q;
			end
		end
	end

	// Scan sequencer: one read issued and one comparison made per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= '0;
			scan_vld_s1 <= 1'b0;
		end else if (scan_start) begin
			issue_q     <= '0;
			scan_vld_s1 <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (issue_q < n_w) begin
				issue_q     <= issue_q + CW'(1);
				scan_vld_s1 <= 1'b1;
			end else begin
				scan_vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			scan_idx_s1 <= issue_q[IW-1:0];
		end
		if (scan_start) begin
			lag_q <= '0;
		end else if (scan_vld_s1) begin
			if (kind_q == KIND_ACCEPT) begin
				if (!own_s1 && full_s1 && !seq_ge) begin
					lag_q[scan_idx_s1] <= 1'b1;
				end
			end else if ((scan_idx_s1 == '0) || (seq_ge && full_s1)) begin
				best_q     <= scan_idx_s1;
				best_seq_q <= seq_eff;
			end
		end
	end

	// Message emission and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_mask_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (emit_load) begin
				emit_mask_q <= emit_mask_d;
			end else if (out_load) begin
				emit_mask_q <= remain;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (messages.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			emit_msg_q  <= emit_msg_d;
			emit_seq_q  <= emit_seq_d;
			emit_host_q <= emit_host_d;
		end
		if (out_load) begin
			out_dest_q <= 4'(pick_idx);
			out_msg_q  <= emit_msg_q;
			out_seq_q  <= emit_seq_q;
			out_host_q <= emit_host_q;
			out_last_q <= remain == '0;
		end
	end

	assign events.ready              = state_q == ST_IDLE;
	assign messages.valid            = out_vld_q;
	assign messages.destination      = out_dest_q;
	assign messages.message          = out_msg_q;
	assign messages.carried_sequence = out_seq_q;
	assign messages.carried_host     = out_host_q;
	assign messages.last             = out_last_q;

`ifndef ASSERT_OFF
	// An accepted event keeps the block busy for at least the decode cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && events.ready) |=> !events.ready)
		else $error("event taken while the previous one is still in decode");

	// The emission state always has at least one destination pending.
	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (emit_mask_q != '0))
		else $error("emission state entered with no destination pending");

	// A scan reports only after its last comparison has drained.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESPOND) |-> (!scan_vld_s1 && (issue_q == n_w)))
		else $error("scan result used before the scan finished");

	// The leader is a host index or the no-leader mark.
	a_leader_range: assert property (@(posedge clk) disable iff (!arst_n)
		leader_q <= NO_LEADER)
		else $error("leader register out of range");
`endif

endmodule

### dv/majority_leader_election_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Majority leader election unit testbench
// Drives link, promise, accept, submit and reject events into the block and
// checks every outgoing message beat against a cycle-free model of the
// election state. Configuration is written and read back over the register
// port between phases. Event bursts and message stalls are randomized.
// ----------------------------------------------------------------------------
module majority_leader_election_unit_test;
	import mle_pkg::*;

	localparam int HOSTS = 16;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS = 18;
	localparam int PHASE_COUNT = 7;
	localparam int MAX_REPORTED = 100;
	localparam logic [2:0] KIND_IGNORED_LOW  = 3'd6;
	localparam logic [2:0] KIND_IGNORED_HIGH = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  peer;
		logic [63:0] peer_sequence;
		logic        take_sequence;
		logic [3:0]  named_host;
	} election_event_t;

	typedef struct packed {
		logic [3:0]  destination;
		logic [1:0]  message;
		logic [63:0] carried_sequence;
		logic [3:0]  carried_host;
		logic        last;
	} msg_beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	mle_event_if events_ch ();
	mle_msg_if messages_ch ();

	majority_leader_election_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.events   (events_ch),
		.messages (messages_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	logic [4:0]  cfg_hosts;
	logic [3:0]  cfg_self;
	logic [63:0] cfg_self_seq;

	logic [63:0] peer_seq_table [HOSTS];
	logic [1:0]  link_table [HOSTS];
	int unsigned linked_hosts;
	int unsigned accept_votes;
	int unsigned leader_id;
	logic [2:0]  election_phase;
	logic [15:0] lagging_hosts;

	msg_beat_t   pending_msgs [$];
	int unsigned mismatch_count;
	int unsigned burst_left;
	int unsigned taken_events;
	int unsigned stall_mode;
	int unsigned stall_left;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_REPORTED) begin
			$display("%0t: mismatch: %s", $time, what);
		end
		mismatch_count++;
	endtask

	function automatic int unsigned active_hosts();
		if (cfg_hosts == 0) begin
			return 1;
		end
		if (cfg_hosts > HOSTS) begin
			return HOSTS;
		end
		return cfg_hosts;
	endfunction

	function automatic logic [63:0] seq_at(input int unsigned i);
		if (i == cfg_self) begin
			return cfg_self_seq;
		end
		return peer_seq_table[i];
	endfunction

	function automatic logic [1:0] level_at(input int unsigned i);
		if (i == cfg_self) begin
			return LEVEL_FULL;
		end
		return link_table[i];
	endfunction

	// Highest sequence among fully linked hosts; later index wins a tie, and
	// host 0 is the starting candidate whatever its link level.
	function automatic int unsigned best_host();
		int unsigned best;
		best = 0;
		for (int unsigned i = 1; i < active_hosts(); i++) begin
			if (seq_at(i) >= seq_at(best) && level_at(i) == LEVEL_FULL) begin
				best = i;
			end
		end
		return best;
	endfunction

	function automatic void queue_msg(input int unsigned dest, input logic [1:0] code,
		input logic [63:0] seq, input int unsigned host);
		msg_beat_t beat;
		beat.destination = 4'(dest);
		beat.message = code;
		beat.carried_sequence = seq;
		beat.carried_host = 4'(host);
		beat.last = 1'b0;
		pending_msgs.push_back(beat);
	endfunction

	function automatic void on_host_linked(input int unsigned host);
		int unsigned n;
		n = active_hosts();
		if (leader_id == cfg_self) begin
			queue_msg(host, MSG_SUBMIT, '0, 0);
			return;
		end
		if (2 * linked_hosts <= n || election_phase > PH_INITIAL) begin
			return;
		end
		if (best_host() != cfg_self) begin
			return;
		end
		accept_votes = 1;
		election_phase = PH_ACCEPT;
		for (int unsigned i = 0; i < n; i++) begin
			if (i != cfg_self) begin
				queue_msg(i, MSG_PROMISE, cfg_self_seq, 0);
			end
		end
	endfunction

	function automatic void on_host_unlinked(input int unsigned host);
		if (linked_hosts > 0) begin
			linked_hosts--;
		end
		if (2 * linked_hosts <= active_hosts() || host == leader_id) begin
			leader_id = NO_LEADER;
			election_phase = PH_INITIAL;
			on_host_linked(host);
		end
	endfunction

	// Updates the election state for one accepted event and queues the
	// messages it sends. Returns zero when the event is ignored.
	function automatic bit predict_messages(input election_event_t ev);
		int unsigned n;
		int unsigned peer;
		int unsigned best;
		int unsigned first;
		msg_beat_t tail;
		n = active_hosts();
		peer = ev.peer;
		first = pending_msgs.size();
		if (ev.kind > KIND_REJECT || peer >= n || peer == cfg_self) begin
			return 1'b0;
		end
		case (ev.kind)
			KIND_LINK_UP: begin
				if (ev.take_sequence) begin
					peer_seq_table[peer] = ev.peer_sequence;
				end
				if (link_table[peer] < LEVEL_FULL) begin
					link_table[peer]++;
					if (link_table[peer] == LEVEL_FULL) begin
						if (linked_hosts < CNT_MAX) begin
							linked_hosts++;
						end
						on_host_linked(peer);
					end
				end
			end
			KIND_LINK_DOWN: begin
				if (link_table[peer] > LEVEL_DOWN) begin
					link_table[peer]--;
					if (link_table[peer] == LEVEL_HALF) begin
						on_host_unlinked(peer);
					end
				end
			end
			KIND_PROMISE: begin
				peer_seq_table[peer] = ev.peer_sequence;
				best = best_host();
				if (peer != best || election_phase > PH_INITIAL) begin
					queue_msg(peer, MSG_REJECT, seq_at(best), best);
				end else begin
					queue_msg(peer, MSG_ACCEPT, '0, 0);
					election_phase = PH_ACCEPT;
				end
			end
			KIND_ACCEPT: begin
				if (election_phase == PH_ACCEPT) begin
					if (accept_votes < CNT_MAX) begin
						accept_votes++;
					end
					if (2 * accept_votes > n) begin
						leader_id = cfg_self;
						lagging_hosts = '0;
						for (int unsigned i = 0; i < n; i++) begin
							if (i != cfg_self && level_at(i) == LEVEL_FULL) begin
								if (seq_at(i) < cfg_self_seq) begin
									lagging_hosts[i] = 1'b1;
								end
								queue_msg(i, MSG_SUBMIT, '0, 0);
							end
						end
						election_phase = (lagging_hosts != '0) ? PH_RECOVERY : PH_READY;
					end
				end
			end
			KIND_SUBMIT: begin
				leader_id = peer;
				election_phase = PH_READY;
			end
			KIND_REJECT: begin
				peer_seq_table[ev.named_host] = ev.peer_sequence;
				on_host_linked(peer);
			end
			default: begin
			end
		endcase
		if (pending_msgs.size() > first) begin
			tail = pending_msgs.pop_back();
			tail.last = 1'b1;
			pending_msgs.push_back(tail);
		end
		return 1'b1;
	endfunction

	function automatic election_event_t make_event(input logic [2:0] kind,
		input int unsigned peer, input logic [63:0] seq = '0, input bit take = 1'b0,
		input int unsigned named = 0);
		election_event_t ev;
		ev.kind = kind;
		ev.peer = 4'(peer);
		ev.peer_sequence = seq;
		ev.take_sequence = take;
		ev.named_host = 4'(named);
		return ev;
	endfunction

	function automatic logic [63:0] random_sequence();
		case ($urandom_range(0, 5))
			0, 1: return 64'($urandom_range(0, 7));
			2: return '1;
			3: return '0;
			4: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int unsigned random_peer();
		int unsigned n;
		int unsigned p;
		n = active_hosts();
		if (n > 1 && $urandom_range(0, 9) < 9) begin
			do begin
				p = $urandom_range(0, n - 1);
			end while (p == cfg_self);
			return p;
		end
		return $urandom_range(0, HOSTS - 1);
	endfunction

	function automatic election_event_t random_event();
		int unsigned pick;
		logic [2:0] kind;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			kind = KIND_LINK_UP;
		end else if (pick < 43) begin
			kind = KIND_LINK_DOWN;
		end else if (pick < 58) begin
			kind = KIND_PROMISE;
		end else if (pick < 73) begin
			kind = KIND_ACCEPT;
		end else if (pick < 78) begin
			kind = KIND_SUBMIT;
		end else if (pick < 93) begin
			kind = KIND_REJECT;
		end else begin
			kind = 3'($urandom_range(KIND_IGNORED_LOW, KIND_IGNORED_HIGH));
		end
		return make_event(kind, random_peer(), random_sequence(), 1'($urandom_range(0, 1)),
			$urandom_range(0, HOSTS - 1));
	endfunction

	// Called just after a rising edge; returns just after the accepting edge.
	task automatic send_event(input election_event_t ev);
		if (burst_left == 0) begin
			events_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
		events_ch.valid <= 1'b1;
		events_ch.kind <= ev.kind;
		events_ch.peer <= ev.peer;
		events_ch.peer_sequence <= ev.peer_sequence;
		events_ch.take_sequence <= ev.take_sequence;
		events_ch.named_host <= ev.named_host;
		do @(posedge clk); while (!events_ch.ready);
		if (predict_messages(ev)) begin
			taken_events++;
		end
	endtask

	task automatic settle();
		events_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_msgs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes one register, then reads it back in the following transfer.
	task automatic set_register(input logic [1:0] index, input logic [63:0] value);
		logic [63:0] stored;
		case (index)
			REG_HOST_COUNT: stored = {59'd0, value[4:0]};
			REG_OWN_INDEX: stored = {60'd0, value[3:0]};
			default: stored = value;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (index)
			REG_HOST_COUNT: cfg_hosts = stored[4:0];
			REG_OWN_INDEX: cfg_self = stored[3:0];
			default: cfg_self_seq = stored;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			report_mismatch($sformatf("register %0d read %h, written %h", index, prdata, stored));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_register_access();
		set_register(REG_OWN_SEQUENCE, '1);
		set_register(REG_HOST_COUNT, 64'd5);
		set_register(REG_OWN_INDEX, 64'd2);
		set_register(REG_OWN_SEQUENCE, 64'h8000_0000_0000_0001);
	endtask

	// Five hosts, this replica at index 2: a promise that is accepted, a
	// promise that is refused, losing the majority, winning an election,
	// late joiners and rejects while leader, then the ignored cases.
	task automatic test_directed_events();
		send_event(make_event(KIND_LINK_UP, 0, 64'd5, 1'b1));
		send_event(make_event(KIND_LINK_UP, 0, '1, 1'b0));
		send_event(make_event(KIND_LINK_UP, 4, '1, 1'b1));
		send_event(make_event(KIND_LINK_UP, 4));
		send_event(make_event(KIND_PROMISE, 4, '1));
		send_event(make_event(KIND_PROMISE, 0, 64'd3));
		send_event(make_event(KIND_LINK_DOWN, 4));
		send_event(make_event(KIND_LINK_DOWN, 4));
		send_event(make_event(KIND_LINK_DOWN, 4));
		send_event(make_event(KIND_LINK_UP, 3, '0, 1'b1));
		send_event(make_event(KIND_LINK_UP, 3));
		send_event(make_event(KIND_LINK_UP, 3, 64'd7, 1'b1));
		send_event(make_event(KIND_ACCEPT, 0));
		send_event(make_event(KIND_ACCEPT, 3));
		send_event(make_event(KIND_LINK_UP, 1));
		send_event(make_event(KIND_LINK_UP, 1));
		send_event(make_event(KIND_REJECT, 3, '1, 1'b1, 15));
		send_event(make_event(KIND_SUBMIT, 0));
		send_event(make_event(KIND_IGNORED_LOW, 1, '1, 1'b1, 15));
		send_event(make_event(KIND_IGNORED_HIGH, 1));
		send_event(make_event(KIND_LINK_UP, 2, '1, 1'b1));
		send_event(make_event(KIND_LINK_UP, 9, '1, 1'b1));
		send_event(make_event(KIND_PROMISE, 1, '0));
		send_event(make_event(KIND_ACCEPT, 1));
		send_event(make_event(KIND_REJECT, 1, '0, 1'b0, 2));
		settle();
	endtask

	// Brings a random subset of hosts fully up, then sends n / 2 + 1 accepts
	// from random peers.
	task automatic run_election();
		int unsigned n;
		n = active_hosts();
		for (int unsigned p = 0; p < n; p++) begin
			if (p != cfg_self && $urandom_range(0, 9) < 7) begin
				send_event(make_event(KIND_LINK_UP, p, random_sequence(), 1'($urandom_range(0, 1))));
				send_event(make_event(KIND_LINK_UP, p, random_sequence(), 1'b1));
			end
		end
		repeat (n / 2 + 1) send_event(make_event(KIND_ACCEPT, random_peer()));
	endtask

	task automatic test_random_phases();
		logic [63:0] hosts_setting;
		logic [63:0] self_setting;
		logic [63:0] seq_setting;
		int unsigned attempts;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					hosts_setting = 64'd16;
					self_setting = 64'd15;
					seq_setting = '1;
				end
				1: begin
					hosts_setting = 64'd0;
					self_setting = 64'd0;
					seq_setting = '0;
				end
				2: begin
					hosts_setting = 64'd2;
					self_setting = 64'd1;
					seq_setting = random_sequence();
				end
				3: begin
					hosts_setting = 64'd31;
					self_setting = 64'd0;
					seq_setting = {$urandom, $urandom};
				end
				default: begin
					hosts_setting = 64'($urandom_range(2, HOSTS));
					self_setting = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, HOSTS - 1))
						: 64'($urandom_range(0, hosts_setting - 1));
					seq_setting = ($urandom_range(0, 1) == 1) ? '1 - 64'($urandom_range(0, 15))
						: random_sequence();
				end
			endcase
			set_register(REG_HOST_COUNT, hosts_setting);
			set_register(REG_OWN_INDEX, self_setting);
			set_register(REG_OWN_SEQUENCE, seq_setting);
			taken_events = 0;
			attempts = 0;
			run_election();
			while (taken_events < PHASE_ITEMS && attempts < 4 * PHASE_ITEMS) begin
				send_event(random_event());
				attempts++;
			end
			settle();
		end
	endtask

	always @(posedge clk) begin : message_sink
		msg_beat_t want;
		if (arst_n) begin
			if (messages_ch.valid && messages_ch.ready) begin
				if (pending_msgs.size() == 0) begin
					report_mismatch($sformatf("unexpected message beat to host %0d",
						messages_ch.destination));
				end else begin
					want = pending_msgs.pop_front();
					if (messages_ch.destination !== want.destination) begin
						report_mismatch($sformatf("destination %0d, expected %0d",
							messages_ch.destination, want.destination));
					end
					if (messages_ch.message !== want.message) begin
						report_mismatch($sformatf("message %0d, expected %0d",
							messages_ch.message, want.message));
					end
					if (messages_ch.carried_sequence !== want.carried_sequence) begin
						report_mismatch($sformatf("carried_sequence %h, expected %h",
							messages_ch.carried_sequence, want.carried_sequence));
					end
					if (messages_ch.carried_host !== want.carried_host) begin
						report_mismatch($sformatf("carried_host %0d, expected %0d",
							messages_ch.carried_host, want.carried_host));
					end
					if (messages_ch.last !== want.last) begin
						report_mismatch($sformatf("last %b, expected %b",
							messages_ch.last, want.last));
					end
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = (stall_mode == 3) ? $urandom_range(2, 12) : $urandom_range(4, 40);
			end
			stall_left--;
			case (stall_mode)
				0: messages_ch.ready <= 1'b1;
				1: messages_ch.ready <= stall_left[0];
				2: messages_ch.ready <= 1'($urandom_range(0, 1));
				default: messages_ch.ready <= 1'b0;
			endcase
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		events_ch.valid = 1'b0;
		events_ch.kind = KIND_LINK_UP;
		events_ch.peer = '0;
		events_ch.peer_sequence = '0;
		events_ch.take_sequence = 1'b0;
		events_ch.named_host = '0;
		messages_ch.ready = 1'b0;
		cfg_hosts = 5'd1;
		cfg_self = '0;
		cfg_self_seq = '0;
		for (int i = 0; i < HOSTS; i++) begin
			peer_seq_table[i] = '0;
			link_table[i] = LEVEL_DOWN;
		end
		linked_hosts = 1;
		accept_votes = 0;
		leader_id = NO_LEADER;
		election_phase = PH_STARTED;
		lagging_hosts = '0;
		mismatch_count = 0;
		burst_left = 0;
		taken_events = 0;
		stall_mode = 0;
		stall_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed_events();
		test_random_phases();
		settle();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
rtl/mle_pkg.sv
rtl/mle_channels.sv
rtl/majority_leader_election_unit.sv
dv/majority_leader_election_unit_test.sv
